FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/cms_pkg.sv
package cms_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_ROWS  = 5;

    localparam int KEY_W      = 64;
    localparam int CNT_W      = 32;
    localparam int TOT_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WREG_W     = 13;
    localparam int RREG_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HASH0 = 3'd2;

    localparam logic [WREG_W-1:0]     RST_WIDTH = 13'd272;
    localparam logic [RREG_W-1:0]     RST_ROWS  = 3'd5;
    localparam logic [CFG_DATA_W-1:0] RST_HASH  = 32'h0001_0001;

    // commands
    localparam logic CMD_INCR  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // remainder unit: bits consumed per cycle and steps per key
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = KEY_W / MOD_BITS;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] inc;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } q_out_t;

    typedef struct packed {
        logic take;
        logic clearing;
    } back_stat_t;

endpackage

FILE: rtl/cms_ram.sv
module cms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

endmodule

FILE: rtl/cms_front.sv
`include "assert_macros.svh"

module cms_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic [cms_pkg::KEY_W-1:0] item_key,
    input  logic [cms_pkg::CNT_W-1:0] increment,
    input  cms_pkg::back_stat_t       stat,
    output cms_pkg::q_out_t           q
);

    cms_pkg::req_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;

    // no requests taken while the counter table is being cleared
    assign in_stall = (cnt_reg == 2'd2) || stat.clearing;
    assign push     = in_valid && !in_stall;

    assign q.valid = (cnt_reg != 2'd0);
    assign q.req   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ stat.take;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, stat.take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{command: command, key: item_key, inc: increment};
        end
    end

    `ASSERT_IMPL(a_take_nonempty, stat.take, cnt_reg != 2'd0)
    `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg != 2'd3)

endmodule

FILE: rtl/cms_back.sv
`include "assert_macros.svh"

module cms_back #(
    parameter int MAX_WIDTH = cms_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = cms_pkg::DEF_MAX_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cms_pkg::CFG_DATA_W-1:0] cfg_data,
    input  cms_pkg::q_out_t                q,
    output cms_pkg::back_stat_t            stat,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cms_pkg::CNT_W-1:0]      estimate,
    output logic [cms_pkg::TOT_W-1:0]      total_count
);

    localparam int DEPTH = MAX_ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int SCW   = $clog2(cms_pkg::MOD_STEPS);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MLO   = 9'b000000100,
        S_MHI   = 9'b000001000,
        S_SUM   = 9'b000010000,
        S_MOD   = 9'b000100000,
        S_READ  = 9'b001000000,
        S_UPD   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [cms_pkg::WREG_W-1:0]     width_reg;
    logic [cms_pkg::RREG_W-1:0]     rows_reg;
    logic [cms_pkg::CFG_DATA_W-1:0] hash_reg [MAX_ROWS];

    logic [AW-1:0]             clr_reg, clr_next;
    logic [RCW-1:0]            row_reg, row_next;
    logic [AW-1:0]             base_reg, base_next;
    logic [SCW-1:0]            step_reg, step_next;
    logic [CW-1:0]             r_reg, r_next;
    logic [cms_pkg::KEY_W-1:0] h_reg, h_next;
    logic [48:0]               lo_reg, lo_next;
    logic [47:0]               hi_reg, hi_next;
    logic [cms_pkg::CNT_W-1:0] best_reg, best_next;
    logic [cms_pkg::TOT_W-1:0] total_reg, total_next;
    cms_pkg::req_t             cur_reg, cur_next;
    logic                      out_valid_reg, out_valid_next;
    logic [cms_pkg::CNT_W-1:0] est_reg, est_next;
    logic [cms_pkg::TOT_W-1:0] tot_out_reg, tot_out_next;

    logic [WW-1:0]             w_eff;
    logic [CW:0]               w_ext;
    logic [RCW-1:0]            rows_eff;
    logic [cms_pkg::CFG_DATA_W-1:0] hash_sel;
    logic [15:0]               mul_a;
    logic [15:0]               mul_b;
    logic                      do_incr;
    logic                      take;
    logic                      ram_we;
    logic [AW-1:0]             ram_addr;
    logic [cms_pkg::CNT_W-1:0] ram_wdata;
    logic [cms_pkg::CNT_W-1:0] ram_rdata;
    logic [cms_pkg::CNT_W-1:0] upd_val;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        w_ext = (CW + 1)'(w_eff);

        if (rows_reg == '0)
            rows_eff = RCW'(1);
        else if (32'(rows_reg) > 32'(MAX_ROWS))
            rows_eff = RCW'(MAX_ROWS);
        else
            rows_eff = RCW'(rows_reg);
    end

    always_comb
    begin
        hash_sel = hash_reg[0];
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if (row_reg == RCW'(i))
                hash_sel = hash_reg[i];
        end
    end

    assign mul_a   = hash_sel[31:16];
    assign mul_b   = hash_sel[15:0];
    assign do_incr = (cur_reg.command == cms_pkg::CMD_INCR);
    assign upd_val = do_incr ? ram_rdata + cur_reg.inc : ram_rdata;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= cms_pkg::RST_WIDTH;
            rows_reg  <= cms_pkg::RST_ROWS;
            for (int i = 0; i < MAX_ROWS; i++)
                hash_reg[i] <= cms_pkg::RST_HASH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cms_pkg::REG_WIDTH: width_reg <= cfg_data[cms_pkg::WREG_W-1:0];
                cms_pkg::REG_ROWS:  rows_reg  <= cfg_data[cms_pkg::RREG_W-1:0];
                default:
                begin
                    for (int i = 0; i < MAX_ROWS; i++)
                    begin
                        if (cfg_index == cms_pkg::CFG_IDX_W'(i + 32'(cms_pkg::REG_HASH0)))
                            hash_reg[i] <= cfg_data;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        logic [CW:0] t;
        logic [CW-1:0] r;

        state_next     = state_reg;
        clr_next       = clr_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        r_next         = r_reg;
        h_next         = h_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        best_next      = best_reg;
        total_next     = total_reg;
        cur_next       = cur_reg;
        est_next       = est_reg;
        tot_out_next   = tot_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        take           = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = base_reg + AW'(r_reg);
        ram_wdata      = upd_val;
        t              = '0;
        r              = r_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q.valid)
                begin
                    take      = 1'b1;
                    cur_next  = q.req;
                    row_next  = '0;
                    base_next = '0;
                    best_next = '1;
                    if (q.req.command == cms_pkg::CMD_INCR)
                        total_next = total_reg + {{32{q.req.inc[31]}}, q.req.inc};
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                lo_next    = 49'(mul_a) * 49'(cur_reg.key[31:0]) + 49'(mul_b);
                state_next = S_MHI;
            end
            S_MHI:
            begin
                hi_next    = 48'(mul_a) * 48'(cur_reg.key[63:32]);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                h_next     = {hi_reg[31:0], 32'b0} + {15'b0, lo_reg};
                r_next     = '0;
                step_next  = '0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                // restoring remainder, msb first
                for (int k = 0; k < cms_pkg::MOD_BITS; k++)
                begin
                    t = {r, h_reg[cms_pkg::KEY_W-1-k]};
                    if (t >= w_ext)
                        t = t - w_ext;
                    r = t[CW-1:0];
                end
                r_next    = r;
                h_next    = h_reg << cms_pkg::MOD_BITS;
                step_next = step_reg + SCW'(1);
                if (step_reg == SCW'(cms_pkg::MOD_STEPS - 1))
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                ram_we = do_incr;
                if (upd_val < best_reg)
                    best_next = upd_val;
                if (row_reg == rows_eff - RCW'(1))
                    state_next = S_OUT;
                else
                begin
                    row_next   = row_reg + RCW'(1);
                    base_next  = base_reg + AW'(w_eff);
                    state_next = S_MLO;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    est_next       = best_reg;
                    tot_out_next   = total_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            row_reg       <= '0;
            step_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            row_reg       <= row_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        r_reg       <= r_next;
        h_reg       <= h_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        best_reg    <= best_next;
        cur_reg     <= cur_next;
        est_reg     <= est_next;
        tot_out_reg <= tot_out_next;
    end

    cms_ram #(
        .WIDTH (cms_pkg::CNT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .we        (ram_we),
        .addr      (ram_addr),
        .wdata     (ram_wdata),
        .rdata_reg (ram_rdata)
    );

    assign stat.take     = take;
    assign stat.clearing = (state_reg == S_CLEAR);
    assign out_valid     = out_valid_reg;
    assign estimate      = est_reg;
    assign total_count   = tot_out_reg;

    `ASSERT_IMPL(a_out_from_done, $rose(out_valid_reg), $past(state_reg == S_OUT))
    `ASSERT_IMPL(a_rem_below_width, state_reg == S_MOD, {1'b0, r_reg} < w_ext)
    `ASSERT_IMPL(a_row_in_range, state_reg == S_UPD, row_reg < rows_eff)

endmodule

FILE: rtl/count_min_sketch.sv
// Count-min sketch: each request (increment or query) hashes its 64-bit key into one
// counter per row in use, column ((a*key+b) mod 2^64) mod width, adds the increment on
// an increment command and returns the unsigned minimum of those counters and the
// running total. Requests are worked one at a time. Per row there come the 16x64 multiply
// in two halves, the final add, the remainder unit at four key bits a cycle, and a read
// of the single-port counter memory with a write on increments. A two-deep request queue
// takes new requests while one is in work. After reset a clearing pass zeroes the counter
// memory, all MAX_ROWS*MAX_WIDTH entries (20480 at the defaults), one entry a cycle, with
// in_stall held high; configuration writes must be made outside work, which the block
// itself does not enforce.
module count_min_sketch #(
    parameter int MAX_WIDTH = cms_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = cms_pkg::DEF_MAX_ROWS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [cms_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cms_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [cms_pkg::KEY_W-1:0]             item_key,
    input  logic signed [cms_pkg::CNT_W-1:0]      increment,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [cms_pkg::CNT_W-1:0]             estimate,
    output logic signed [cms_pkg::TOT_W-1:0]      total_count
);

    cms_pkg::q_out_t           q;
    cms_pkg::back_stat_t       stat;
    logic [cms_pkg::TOT_W-1:0] total_u;

    cms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .item_key  (item_key),
        .increment (increment),
        .stat      (stat),
        .q         (q)
    );

    cms_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q           (q),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .estimate    (estimate),
        .total_count (total_u)
    );

    assign total_count = total_u;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_CNT     = cms_pkg::DEF_MAX_ROWS * cms_pkg::DEF_MAX_WIDTH;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 150;
    localparam logic [cms_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [cms_pkg::CNT_W-1:0] est;
        logic [cms_pkg::TOT_W-1:0] tot;
    } sketch_result_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_write;
    logic [cms_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [cms_pkg::CFG_DATA_W-1:0]        cfg_data;
    logic                                  in_valid;
    logic                                  in_stall;
    logic                                  command;
    logic [cms_pkg::KEY_W-1:0]             item_key;
    logic signed [cms_pkg::CNT_W-1:0]      increment;
    logic                                  out_valid;
    logic                                  out_stall;
    logic [cms_pkg::CNT_W-1:0]             estimate;
    logic signed [cms_pkg::TOT_W-1:0]      total_count;

    // predictor state
    logic [cms_pkg::CNT_W-1:0]      sketch_cnt [NUM_CNT];
    logic [cms_pkg::TOT_W-1:0]      sketch_total;
    logic [cms_pkg::WREG_W-1:0]     width_reg;
    logic [cms_pkg::RREG_W-1:0]     rows_reg;
    logic [cms_pkg::CFG_DATA_W-1:0] hash_reg [cms_pkg::DEF_MAX_ROWS];

    sketch_result_t pending_results[$];
    int  cycle_count;
    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    logic [cms_pkg::KEY_W-1:0] key_pool [16];

    count_min_sketch DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .item_key    (item_key),
        .increment   (increment),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .estimate    (estimate),
        .total_count (total_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= (($urandom % 100) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        sketch_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result estimate=%h total=%h",
                         $time, estimate, total_count);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (estimate !== exp_res.est)
                begin
                    $display("%0t: estimate expected %h actual %h",
                             $time, exp_res.est, estimate);
                    error_count++;
                end
                if (total_count !== exp_res.tot)
                begin
                    $display("%0t: total_count expected %h actual %h",
                             $time, exp_res.tot, total_count);
                    error_count++;
                end
            end
        end
    end

    task automatic sketch_update(input logic cmd, input logic [cms_pkg::KEY_W-1:0] key,
                                 input logic [cms_pkg::CNT_W-1:0] inc);
        int unsigned w;
        int unsigned r;
        logic [63:0] h;
        int unsigned col;
        int unsigned pos;
        sketch_result_t res;
        w = (width_reg == 0) ? 1 :
            (width_reg > cms_pkg::DEF_MAX_WIDTH) ? cms_pkg::DEF_MAX_WIDTH : width_reg;
        r = (rows_reg == 0) ? 1 :
            (rows_reg > cms_pkg::DEF_MAX_ROWS) ? cms_pkg::DEF_MAX_ROWS : rows_reg;
        res.est = '1;
        if (cmd == cms_pkg::CMD_INCR)
            sketch_total = sketch_total + {{32{inc[31]}}, inc};
        for (int j = 0; j < r; j++)
        begin
            h = {48'd0, hash_reg[j][31:16]} * key + {48'd0, hash_reg[j][15:0]};
            col = 32'(h % w);
            pos = j * w + col;
            if (cmd == cms_pkg::CMD_INCR)
                sketch_cnt[pos] = sketch_cnt[pos] + inc;
            if (sketch_cnt[pos] < res.est)
                res.est = sketch_cnt[pos];
        end
        res.tot = sketch_total;
        pending_results.push_back(res);
    endtask

    task automatic send_request(input logic cmd, input logic [cms_pkg::KEY_W-1:0] key,
                                input logic [cms_pkg::CNT_W-1:0] inc);
        in_valid  <= 1'b1;
        command   <= cmd;
        item_key  <= key;
        increment <= inc;
        do
            @(posedge clk);
        while (in_stall);
        sketch_update(cmd, key, inc);
        if (($urandom % 100) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (($urandom % 100) < send_idle_pct);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic [cms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cms_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == cms_pkg::REG_WIDTH)
            width_reg = data[cms_pkg::WREG_W-1:0];
        else if (idx == cms_pkg::REG_ROWS)
            rows_reg = data[cms_pkg::RREG_W-1:0];
        else if (idx < cms_pkg::REG_HASH0 + cms_pkg::DEF_MAX_ROWS)
            hash_reg[idx - cms_pkg::REG_HASH0] = data;
    endtask

    task automatic configure(input logic [cms_pkg::CFG_DATA_W-1:0] w,
                             input logic [cms_pkg::CFG_DATA_W-1:0] r,
                             input logic random_hash);
        reg_write(cms_pkg::REG_WIDTH, w);
        reg_write(cms_pkg::REG_ROWS, r);
        for (int j = 0; j < cms_pkg::DEF_MAX_ROWS; j++)
            reg_write(cms_pkg::CFG_IDX_W'(cms_pkg::REG_HASH0 + j),
                      random_hash ? $urandom : cms_pkg::RST_HASH);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [cms_pkg::KEY_W-1:0] pick_key();
        if (($urandom % 100) < 70)
            return key_pool[4'($urandom)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [cms_pkg::CNT_W-1:0] pick_inc();
        case ($urandom % 4)
            0: return $urandom;
            1: return $urandom_range(0, 20) - 10;
            2: return ($urandom % 2) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic test_directed_defaults;
        send_request(cms_pkg::CMD_QUERY, 64'd0, 32'd0);
        send_request(cms_pkg::CMD_INCR, 64'd0, 32'h7fff_ffff);
        send_request(cms_pkg::CMD_INCR, 64'd0, 32'h7fff_ffff);
        send_request(cms_pkg::CMD_INCR, '1, 32'h8000_0000);
        send_request(cms_pkg::CMD_INCR, '1, 32'hffff_ffff);
        send_request(cms_pkg::CMD_QUERY, '1, 32'hffff_ffff);
        send_request(cms_pkg::CMD_INCR, 64'h8000_0000_0000_0000, 32'd0);
        send_request(cms_pkg::CMD_INCR, 64'h5555_5555_5555_5555, 32'd1);
        send_request(cms_pkg::CMD_INCR, 64'haaaa_aaaa_aaaa_aaaa, 32'hffff_fffe);
        send_request(cms_pkg::CMD_QUERY, 64'h5555_5555_5555_5555, 32'd0);
        drain();
    endtask

    task automatic test_register_corners;
        // zero width and zero rows fall back to one
        configure(32'd0, 32'd0, 1'b0);
        send_request(cms_pkg::CMD_INCR, 64'd7, 32'd3);
        send_request(cms_pkg::CMD_QUERY, '1, 32'd0);
        drain();
        // oversize width and rows saturate
        configure(32'hffff_ffff, 32'd7, 1'b1);
        send_request(cms_pkg::CMD_INCR, 64'd9, 32'd5);
        send_request(cms_pkg::CMD_QUERY, 64'd9, 32'd0);
        drain();
        configure(32'd4096, 32'd6, 1'b0);
        reg_write(cms_pkg::REG_HASH0, 32'hffff_ffff);
        reg_write(cms_pkg::CFG_IDX_W'(cms_pkg::REG_HASH0 + 1), 32'd0);
        // write to an index that maps to no register
        reg_write(REG_UNUSED, 32'h1234_5678);
        cfg_write <= 1'b0;
        send_request(cms_pkg::CMD_INCR, '1, 32'd2);
        send_request(cms_pkg::CMD_QUERY, '1, 32'd0);
        send_request(cms_pkg::CMD_INCR, 64'd1, 32'h8000_0000);
        drain();
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_request(($urandom % 100) < 30 ? cms_pkg::CMD_QUERY : cms_pkg::CMD_INCR,
                         pick_key(), pick_inc());
        drain();
    endtask

    task automatic test_random_configs;
        int s_pct [4] = '{0, 81, 0, 8};
        int r_pct [4] = '{0, 0, 81, 8};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = s_pct[ph];
            recv_stall_pct = r_pct[ph];
            configure($urandom_range(1, 16), $urandom_range(1, 5), 1'b1);
            test_random_traffic(150);
            configure($urandom_range(1, 8191), $urandom_range(0, 7), 1'b1);
            test_random_traffic(150);
            configure(ph[0] ? 32'd4096 : 32'd1, ph[1] ? 32'd5 : 32'd1, 1'b1);
            test_random_traffic(130);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = cms_pkg::CMD_INCR;
        item_key       = '0;
        increment      = '0;
        out_stall      = 1'b0;
        cycle_count    = 0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NUM_CNT; i++)
            sketch_cnt[i] = '0;
        sketch_total = '0;
        width_reg    = cms_pkg::RST_WIDTH;
        rows_reg     = cms_pkg::RST_ROWS;
        for (int j = 0; j < cms_pkg::DEF_MAX_ROWS; j++)
            hash_reg[j] = cms_pkg::RST_HASH;
        for (int k = 0; k < 16; k++)
            key_pool[k] = {$urandom, $urandom};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_register_corners();
        test_random_configs();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cms_pkg.sv
rtl/cms_ram.sv
rtl/cms_front.sv
rtl/cms_back.sv
rtl/count_min_sketch.sv
verif/tb_top.sv
